[sv/pfs_pkg.sv]
// Package for planck_fraction_series: widths, fixed-point constants and the
// request types of the shared multiplier and divider. No dependencies.
package pfs_pkg;

    localparam int FRAC_BITS = 48;
    localparam int MAX_TERMS = 33;
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam int NM_W      = 24;
    localparam int TK_W      = 16;
    localparam int TERMS_W   = 6;
    localparam int FRAC_SH   = 52 - FRAC_BITS;

    localparam logic [43:0] Q44_MAX   = 44'hFFF_FFFF_FFFF;
    localparam logic [63:0] Y_NUM     = 64'd42949672960000000;
    localparam logic [63:0] C2_Q32    = 64'd6179555996;
    localparam logic [63:0] T74_Q32   = 64'd31782757990;
    localparam logic [63:0] T42_Q32   = 64'd18038862643;
    localparam logic [63:0] T045_Q32  = 64'd1932735283;
    localparam logic [63:0] K23_Q32   = 64'd9878424781;
    localparam logic [63:0] K1296_Q32 = 64'd55662776156;
    localparam logic [63:0] K4666_Q32 = 64'd200403174031;
    localparam logic [63:0] KMAX_Q32  = 64'(MAX_TERMS) << 32;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [63:0] SCALE_Q32 = 64'd661382014;
    localparam logic [63:0] THREE_Q32 = 64'd3 << 32;
    localparam logic [63:0] SIX_Q32   = 64'd6 << 32;
    localparam logic [63:0] ONE_Q62   = 64'd1 << 62;
    localparam logic [63:0] ONE_Q52   = 64'd1 << 52;
    localparam logic [5:0]  K_LIMIT   = 6'd52;
    localparam logic [4:0]  TAYLOR_N  = 5'd20;
    // t at or above this gives k above K_LIMIT
    localparam logic [63:0] KOVF_Q32  = LN2_Q32 * 64'(K_LIMIT + 6'd1);

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic        sel62;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    function automatic logic [23:0] pow4(input logic [5:0] n);
        logic [11:0] n2;
        n2 = 12'(n) * 12'(n);
        return 24'(n2) * 24'(n2);
    endfunction

endpackage

[sv/pfs_item_if.sv]
// Input channel of planck_fraction_series: valid/ready plus one item.
// Depends on pfs_pkg.
interface pfs_item_if;
    import pfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [NM_W-1:0]   wavelength_nm;
    logic [TK_W-1:0]   temperature_k;
    modport source (output valid, wavelength_nm, temperature_k, input ready);
    modport sink   (input valid, wavelength_nm, temperature_k, output ready);
endinterface

[sv/pfs_result_if.sv]
// Output channel of planck_fraction_series: valid/ready plus one result.
// Depends on pfs_pkg.
interface pfs_result_if;
    import pfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [OUT_W-1:0]   fraction_q48;
    logic [TERMS_W-1:0] terms_used;
    modport source (output valid, fraction_q48, terms_used, input ready);
    modport sink   (input valid, fraction_q48, terms_used, output ready);
endinterface

[sv/pfs_mul.sv]
// Shared 64x64 multiplier: one 32x32 partial product per cycle, result
// floor(a*b/2^32) or floor(a*b/2^62), low 64 bits. Depends on pfs_pkg.
module pfs_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pfs_pkg::mul_req_t req,
    output logic              done,
    output logic [63:0]       res
);
    import pfs_pkg::*;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         done_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic         sel_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [1:0]   idx;
    logic [1:0]   pidx;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_sh;

    always_comb
    begin
        idx    = cnt_reg[1:0];
        pidx   = 2'(cnt_reg - 3'd1);
        a_part = idx[1] ? a_reg[63:32] : a_reg[31:0];
        b_part = idx[0] ? b_reg[63:32] : b_reg[31:0];
        case (pidx)
            2'd0:    pp_sh = {64'd0, pp_reg};
            2'd1:    pp_sh = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_sh = {32'd0, pp_reg, 32'd0};
            2'd3:    pp_sh = {pp_reg, 64'd0};
            default: pp_sh = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            sel_reg <= req.sel62;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
                pp_reg <= 64'(a_part) * 64'(b_part);
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign res  = sel_reg ? acc_reg[125:62] : acc_reg[95:32];

endmodule

[sv/pfs_div.sv]
// Shared 64-bit restoring divider, one quotient bit per cycle.
// Depends on pfs_pkg.
module pfs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfs_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quo
);
    import pfs_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] q_reg;
    logic [63:0] rem_reg;
    logic [63:0] dvs_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[63]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= ge ? diff[63:0] : trial[63:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[sv/planck_fraction_series.sv]
// Top level of planck_fraction_series: sequencer around one shared multiplier
// and one shared divider. Depends on pfs_pkg, pfs_item_if, pfs_result_if,
// pfs_mul, pfs_div.
//
// Fraction of blackbody power below a wavelength, from the Planck series.
// One item at a time: ready is high only while the block is idle. Each
// series term is skipped when its exponential is out of range; otherwise it
// takes a 6-step compare and subtract for the ln2 reduction, 20 Taylor steps
// of one multiply and one divide each, three polynomial multiplies and the
// divide by n^4. Up to 32 terms are summed.
// A finished result is held in an output register until it is taken.
module planck_fraction_series (
    input logic         clk,
    input logic         rst_n,
    pfs_item_if.sink    item,
    pfs_result_if.source result
);
    import pfs_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_YDIV = 15'h0002,
        S_ZMUL = 15'h0004,
        S_XMUL = 15'h0008,
        S_NEXT = 15'h0010,
        S_KDIV = 15'h0020,
        S_TMUL = 15'h0040,
        S_TDIV = 15'h0080,
        S_EXPD = 15'h0100,
        S_P1   = 15'h0200,
        S_P2   = 15'h0400,
        S_P3   = 15'h0800,
        S_NDIV = 15'h1000,
        S_FMUL = 15'h2000,
        S_DONE = 15'h4000
    } state_t;

    state_t             state_reg, state_next;
    logic [43:0]        y_reg, y_next;
    logic [43:0]        z_reg, z_next;
    logic               mid_reg, mid_next;
    logic [5:0]         n_reg, n_next;
    logic [5:0]         terms_reg, terms_next;
    logic [49:0]        t_reg, t_next;
    logic [5:0]         k_reg, k_next;
    logic [37:0]        r_reg, r_next;
    logic [2:0]         kb_reg, kb_next;
    logic [61:0]        big_reg, big_next;
    logic [4:0]         j_reg, j_next;
    logic [63:0]        se_reg, se_next;
    logic [53:0]        e_reg, e_next;
    logic [63:0]        sum_reg, sum_next;
    logic [OUT_W-1:0]   f_reg, f_next;
    logic               ov_reg;
    logic [OUT_W-1:0]   frac_reg;
    logic [TERMS_W-1:0] tu_reg;
    logic               load;

    mul_req_t    mreq;
    div_req_t    dreq;
    logic        mdone, ddone;
    logic [63:0] mres, quo;

    logic [39:0] d;
    logic [43:0] sat;
    logic [63:0] diff;
    logic [31:0] xw;
    logic [5:0]  x6;
    logic [63:0] ev;
    logic [63:0] pv;
    logic [63:0] fsat;
    logic [63:0] fs;
    logic [49:0] tv;
    logic [37:0] lsh;
    logic        kge;
    logic [37:0] r_sub;
    logic [5:0]  k_sub;

    pfs_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .res(mres));
    pfs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(quo));

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        mid_next   = mid_reg;
        n_next     = n_reg;
        terms_next = terms_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        kb_next    = kb_reg;
        big_next   = big_reg;
        j_next     = j_reg;
        se_next    = se_reg;
        e_next     = e_reg;
        sum_next   = sum_reg;
        f_next     = f_reg;
        mreq       = '0;
        dreq       = '0;
        load       = 1'b0;
        d          = 40'(item.wavelength_nm) * 40'(item.temperature_k);
        sat        = (quo > 64'(Q44_MAX)) ? Q44_MAX : quo[43:0];
        diff       = (mid_reg ? K1296_Q32 : KMAX_Q32) - mres;
        xw         = diff[63:32];
        x6         = (xw > 32'(MAX_TERMS)) ? 6'(MAX_TERMS) : xw[5:0];
        ev         = se_reg >> (7'(k_reg) + 7'd10);
        pv         = mres + SIX_Q32;
        fsat       = (mres > ONE_Q52) ? ONE_Q52 : mres;
        fs         = (FRAC_SH >= 0) ? (fsat >> FRAC_SH) : (fsat << (-FRAC_SH));
        tv         = 50'(n_reg) * 50'(z_reg);
        lsh        = 38'(LN2_Q32) << kb_reg;
        kge        = r_reg >= lsh;
        r_sub      = kge ? r_reg - lsh : r_reg;
        k_sub      = k_reg | (kge ? (6'd1 << kb_reg) : 6'd0);

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    sum_next = '0;
                    if (d == 40'd0)
                    begin
                        y_next     = Q44_MAX;
                        mreq       = '{1'b1, 64'(Q44_MAX), C2_Q32, 1'b0};
                        state_next = S_ZMUL;
                    end
                    else
                    begin
                        dreq       = '{1'b1, Y_NUM, 64'(d)};
                        state_next = S_YDIV;
                    end
                end
            end
            S_YDIV:
            begin
                if (ddone)
                begin
                    y_next     = sat;
                    mreq       = '{1'b1, 64'(sat), C2_Q32, 1'b0};
                    state_next = S_ZMUL;
                end
            end
            S_ZMUL:
            begin
                if (mdone)
                begin
                    z_next = (mres > 64'(Q44_MAX)) ? Q44_MAX : mres[43:0];
                    if (64'(y_reg) >= T74_Q32)
                    begin
                        n_next     = 6'd3;
                        terms_next = 6'd3;
                        state_next = S_NEXT;
                    end
                    else if (64'(y_reg) >= T42_Q32)
                    begin
                        n_next     = 6'd1;
                        terms_next = 6'd1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        mid_next   = 64'(y_reg) >= T045_Q32;
                        mreq       = '{1'b1, (64'(y_reg) >= T045_Q32) ? K23_Q32 : K4666_Q32,
                                       64'(y_reg), 1'b0};
                        state_next = S_XMUL;
                    end
                end
            end
            S_XMUL:
            begin
                if (mdone)
                begin
                    n_next     = (x6 == 6'd0) ? 6'd0 : x6 - 6'd1;
                    terms_next = (x6 == 6'd0) ? 6'd0 : x6 - 6'd1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (n_reg == 6'd0)
                begin
                    mreq       = '{1'b1, sum_reg, SCALE_Q32, 1'b0};
                    state_next = S_FMUL;
                end
                else if (64'(tv) >= KOVF_Q32)
                begin
                    n_next = n_reg - 6'd1;
                end
                else
                begin
                    t_next     = tv;
                    r_next     = tv[37:0];
                    k_next     = 6'd0;
                    kb_next    = 3'd5;
                    state_next = S_KDIV;
                end
            end
            S_KDIV:
            begin
                // one quotient bit of t/ln2 per cycle, msb first
                r_next = r_sub;
                k_next = k_sub;
                if (kb_reg == 3'd0)
                begin
                    big_next   = {r_sub[31:0], 30'd0};
                    se_next    = ONE_Q62;
                    j_next     = 5'd1;
                    mreq       = '{1'b1, ONE_Q62, {2'b00, r_sub[31:0], 30'd0}, 1'b1};
                    state_next = S_TMUL;
                end
                else
                    kb_next = kb_reg - 3'd1;
            end
            S_TMUL:
            begin
                if (mdone)
                begin
                    dreq       = '{1'b1, mres, 64'(j_reg)};
                    state_next = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (ddone)
                begin
                    se_next = j_reg[0] ? se_reg - quo : se_reg + quo;
                    if (j_reg == TAYLOR_N)
                        state_next = S_EXPD;
                    else
                    begin
                        j_next     = j_reg + 5'd1;
                        mreq       = '{1'b1, quo, {2'b00, big_reg}, 1'b1};
                        state_next = S_TMUL;
                    end
                end
            end
            S_EXPD:
            begin
                e_next = ev[53:0];
                if (ev == 64'd0)
                begin
                    n_next     = n_reg - 6'd1;
                    state_next = S_NEXT;
                end
                else
                begin
                    mreq       = '{1'b1, 64'(t_reg), 64'(t_reg) + THREE_Q32, 1'b0};
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                if (mdone)
                begin
                    mreq       = '{1'b1, 64'(t_reg), pv, 1'b0};
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                if (mdone)
                begin
                    mreq       = '{1'b1, 64'(e_reg), pv, 1'b0};
                    state_next = S_P3;
                end
            end
            S_P3:
            begin
                if (mdone)
                begin
                    dreq       = '{1'b1, mres, 64'(pow4(n_reg))};
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (ddone)
                begin
                    sum_next   = sum_reg + quo;
                    n_next     = n_reg - 6'd1;
                    state_next = S_NEXT;
                end
            end
            S_FMUL:
            begin
                if (mdone)
                begin
                    f_next     = fs[OUT_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            terms_reg <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            terms_reg <= terms_next;
            k_reg     <= k_next;
            if (load)
                ov_reg <= 1'b1;
            else if (result.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        z_reg   <= z_next;
        mid_reg <= mid_next;
        t_reg   <= t_next;
        r_reg   <= r_next;
        kb_reg  <= kb_next;
        big_reg <= big_next;
        j_reg   <= j_next;
        se_reg  <= se_next;
        e_reg   <= e_next;
        sum_reg <= sum_next;
        f_reg   <= f_next;
        if (load)
        begin
            frac_reg <= f_reg;
            tu_reg   <= terms_reg;
        end
    end

    assign item.ready          = (state_reg == S_IDLE);
    assign result.valid        = ov_reg;
    assign result.fraction_q48 = frac_reg;
    assign result.terms_used   = tu_reg;

`ifndef SYNTH
    a_frac_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.fraction_q48 <= (OUT_W'(1) << FRAC_BITS))
        else $error("fraction above one");
    a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.terms_used < TERMS_W'(MAX_TERMS))
        else $error("term count out of range");
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> n_reg <= terms_reg)
        else $error("term index above term count");
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TMUL) |-> k_reg <= K_LIMIT)
        else $error("exponent shift out of range");
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");
`endif

endmodule
